FILE: rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared constants, opcodes, and the controller/datapath command and status
// types.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned MAX_THREADS_DEF = 64;
  localparam int unsigned CREDIT_W_DEF    = 16;
  localparam int unsigned NUM_CORES       = 4;
  localparam int unsigned CORE_W          = 2;
  localparam int unsigned TIME_W          = 64;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned ST_W            = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_LAUNCH  = 3'd1,
    OP_PAUSE   = 3'd2,
    OP_UNPAUSE = 3'd3,
    OP_REMOVE  = 3'd4
  } op_e;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_REFUSED  = 2'd1;
  localparam logic [ST_W-1:0] ST_CORE_OFF = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACCT,
    S_PUT1,
    S_PUT2,
    S_TAKE_RD,
    S_TAKE_WR,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_READ,
    CMD_ACCT,
    CMD_PUT1,
    CMD_PUT2,
    CMD_TAKE_RD,
    CMD_TAKE_WR,
    CMD_FIN
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CHARGE,
    ACT_LAUNCH,
    ACT_PAUSE,
    ACT_CRED_DEC,
    ACT_CRED_INC,
    ACT_UNPAUSE
  } act_e;

  typedef struct packed {
    cmd_e            op;
    act_e            act;
    logic [ST_W-1:0] status;
    logic            put_cur;
    logic            take_head;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            en_ok;
    logic            cur_ok;
    logic            thr_ok;
    logic            closed;
    logic            paused;
    logic            cred_nz;
    logic            force_p;
    logic            out_busy;
  } sts_t;

endpackage

FILE: rtl/core/round_robin_thread_scheduler.sv
// Sequencing: each transaction is loaded, read, accounted and finished; a tick that
// requeues and dispatches takes the longest path through the sequencer.
// Operation: one operation at a time; the next transaction is taken only once
// the controller is back in idle after the read, enqueue and dequeue steps
// that it walks through the link memories, and the result slot is free.
// Reset: queue empty, all threads blocked and closed, cores idle, mask clear.
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Ready-queue scheduler top level: controller and datapath.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler import rrts_pkg::*; #(
  parameter int unsigned MaxThreads = MAX_THREADS_DEF,
  parameter int unsigned CreditW    = CREDIT_W_DEF,
  localparam int unsigned TW        = $clog2(MaxThreads),
  localparam int unsigned CW        = $clog2(MaxThreads + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [NUM_CORES-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      opcode_i,
  input  logic [CORE_W-1:0]    core_index_i,
  input  logic [TW-1:0]        thread_index_i,
  input  logic                 force_pause_i,
  input  logic [TIME_W-1:0]    now_time_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ST_W-1:0]      status_o,
  output logic [TW-1:0]        running_thread_o,
  output logic                 running_valid_o,
  output logic [TIME_W-1:0]    charged_time_o,
  output logic [CW-1:0]        queue_count_o
);

  cmd_t cmd;
  sts_t sts;

  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rrts_dp #(
    .MaxThreads (MaxThreads),
    .CreditW    (CreditW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .opcode_i         (opcode_i),
    .core_index_i     (core_index_i),
    .thread_index_i   (thread_index_i),
    .force_pause_i    (force_pause_i),
    .now_time_i       (now_time_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .running_thread_o (running_thread_o),
    .running_valid_o  (running_valid_o),
    .charged_time_o   (charged_time_o),
    .queue_count_o    (queue_count_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

FILE: rtl/core/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one operation through read, accounting, enqueue, dequeue and
// result steps, and commands the datapath.
// ----------------------------------------------------------------------------
module rrts_ctrl import rrts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // Take a transaction only when idle and the result slot frees up
  assign in_ready_o = (state_q == S_IDLE) && (!sts_i.out_busy || out_ready_i);

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d           = state_q;
    cmd_o.op          = CMD_NONE;
    cmd_o.act         = ACT_NONE;
    cmd_o.status      = ST_REFUSED;
    cmd_o.put_cur     = (sts_i.op == OP_TICK);
    cmd_o.take_head   = (sts_i.op == OP_TICK) || (sts_i.op == OP_PAUSE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        cmd_o.op = CMD_READ;
        state_d  = S_ACCT;
      end
      S_ACCT: begin
        cmd_o.op = CMD_ACCT;
        state_d  = S_DONE;
        unique case (sts_i.op)
          OP_TICK: begin
            if (!sts_i.en_ok) begin
              cmd_o.status = ST_CORE_OFF;
            end else if (sts_i.cur_ok) begin
              cmd_o.act = ACT_CHARGE;
              state_d   = S_PUT1;
            end else begin
              state_d = S_TAKE_RD;
            end
          end
          OP_LAUNCH: begin
            if (sts_i.thr_ok) begin
              cmd_o.act    = ACT_LAUNCH;
              cmd_o.status = ST_OK;
              state_d      = S_PUT1;
            end
          end
          OP_PAUSE: begin
            if (sts_i.cur_ok) begin
              if (!sts_i.force_p && sts_i.cred_nz) begin
                cmd_o.act = ACT_CRED_DEC;
              end else begin
                cmd_o.act = ACT_PAUSE;
                state_d   = S_TAKE_RD;
              end
            end
          end
          OP_UNPAUSE: begin
            if (sts_i.thr_ok && !sts_i.closed) begin
              if (sts_i.paused) begin
                cmd_o.act    = ACT_UNPAUSE;
                cmd_o.status = ST_OK;
                state_d      = S_PUT1;
              end else begin
                cmd_o.act = ACT_CRED_INC;
              end
            end
          end
          OP_REMOVE: begin
            if (sts_i.thr_ok) begin
              cmd_o.status = ST_OK;
              state_d      = S_TAKE_RD;
            end
          end
          default: begin
            cmd_o.status = ST_REFUSED;
          end
        endcase
      end
      S_PUT1: begin
        cmd_o.op = CMD_PUT1;
        state_d  = S_PUT2;
      end
      S_PUT2: begin
        cmd_o.op = CMD_PUT2;
        state_d  = (sts_i.op == OP_TICK) ? S_TAKE_RD : S_DONE;
      end
      S_TAKE_RD: begin
        cmd_o.op = CMD_TAKE_RD;
        state_d  = S_TAKE_WR;
      end
      S_TAKE_WR: begin
        cmd_o.op = CMD_TAKE_WR;
        state_d  = S_DONE;
      end
      S_DONE: begin
        cmd_o.op = CMD_FIN;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/rrts_dp.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Ready queue links, thread flags, run-time and credit stores, per-core
// state and the result register.
// ----------------------------------------------------------------------------
module rrts_dp import rrts_pkg::*; #(
  parameter int unsigned MaxThreads = MAX_THREADS_DEF,
  parameter int unsigned CreditW    = CREDIT_W_DEF,
  localparam int unsigned TW        = $clog2(MaxThreads),
  localparam int unsigned CW        = $clog2(MaxThreads + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [NUM_CORES-1:0] cfg_wdata_i,
  input  logic [OP_W-1:0]      opcode_i,
  input  logic [CORE_W-1:0]    core_index_i,
  input  logic [TW-1:0]        thread_index_i,
  input  logic                 force_pause_i,
  input  logic [TIME_W-1:0]    now_time_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [ST_W-1:0]      status_o,
  output logic [TW-1:0]        running_thread_o,
  output logic                 running_valid_o,
  output logic [TIME_W-1:0]    charged_time_o,
  output logic [CW-1:0]        queue_count_o,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o
);

  // Memories
  logic [TW-1:0]      next_mem [MaxThreads];
  logic [TW-1:0]      prev_mem [MaxThreads];
  logic [TIME_W-1:0]  rt_mem   [MaxThreads];
  logic [CreditW-1:0] cred_mem [MaxThreads];

  // Control state
  logic [NUM_CORES-1:0]  mask_q;
  logic [TW-1:0]         head_q, tail_q;
  logic [CW-1:0]         size_q;
  logic [MaxThreads-1:0] inq_q, paused_q, blocked_q, closed_q, rtv_q, crv_q;
  logic [TW-1:0]         cur_q [NUM_CORES];
  logic [NUM_CORES-1:0]  curv_q;
  logic [TIME_W-1:0]     sw_q [NUM_CORES];
  logic                  out_valid_q, pg_q, tk_go_q;

  // Operation payload and work registers
  logic [OP_W-1:0]    op_q;
  logic [CORE_W-1:0]  c_q;
  logic [TW-1:0]      t_q, ta_q, pp_q, x_q, n_rd_q, p_rd_q;
  logic               force_q, rtv_rd_q, crv_rd_q;
  logic [TIME_W-1:0]  now_q, el_q, rt_rd_q, charged_q;
  logic [CreditW-1:0] cred_rd_q;
  logic [ST_W-1:0]    status_q;

  // Result register
  logic [ST_W-1:0]   res_status_q;
  logic [TW-1:0]     res_thread_q;
  logic              res_valid_q;
  logic [TIME_W-1:0] res_charged_q;
  logic [CW-1:0]     res_count_q;

  logic               core_ok, en_ok, cur_ok, thr_ok, pg, tk_go;
  logic [TW-1:0]      ta, pp, x;
  logic [TIME_W-1:0]  rt_val, sum;
  logic [CreditW-1:0] cred_val;
  logic               acct_chg;

  logic          next_we, prev_we, cred_we;
  logic [TW-1:0] next_wa, next_wd, prev_wa, prev_wd;
  logic [CreditW-1:0] cred_wd;

  // Decode operands
  assign core_ok  = ({1'b0, c_q} < (CORE_W + 1)'(NUM_CORES));
  assign en_ok    = core_ok && mask_q[c_q];
  assign cur_ok   = core_ok && curv_q[c_q];
  assign thr_ok   = ({1'b0, t_q} < (TW + 1)'(MaxThreads));
  assign ta       = ((op_q == OP_TICK) || (op_q == OP_PAUSE)) ? cur_q[c_q] : t_q;
  assign rt_val   = rtv_rd_q ? rt_rd_q : '0;
  assign cred_val = crv_rd_q ? cred_rd_q : '0;
  assign sum      = rt_val + el_q;
  assign acct_chg = (cmd_i.op == CMD_ACCT) &&
                    ((cmd_i.act == ACT_CHARGE) || (cmd_i.act == ACT_PAUSE));
  assign pp       = cmd_i.put_cur ? ta_q : t_q;
  assign pg       = !inq_q[pp];
  assign x        = cmd_i.take_head ? head_q : t_q;
  assign tk_go    = inq_q[x] && (size_q > CW'(1));

  assign sts_o.op       = op_q;
  assign sts_o.en_ok    = en_ok;
  assign sts_o.cur_ok   = cur_ok;
  assign sts_o.thr_ok   = thr_ok;
  assign sts_o.closed   = closed_q[t_q];
  assign sts_o.paused   = paused_q[t_q];
  assign sts_o.cred_nz  = (cred_val != '0);
  assign sts_o.force_p  = force_q;
  assign sts_o.out_busy = out_valid_q;

  // Link and credit write ports
  always_comb begin
    next_we = 1'b0;
    next_wa = tail_q;
    next_wd = pp;
    prev_we = 1'b0;
    prev_wa = pp;
    prev_wd = tail_q;
    if ((cmd_i.op == CMD_PUT1) && pg && (size_q != '0)) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end else if ((cmd_i.op == CMD_PUT2) && pg_q) begin
      next_we = 1'b1;
      next_wa = pp_q;
      next_wd = head_q;
    end else if ((cmd_i.op == CMD_TAKE_WR) && tk_go_q) begin
      next_we = 1'b1;
      next_wd = n_rd_q;
      if (x_q != head_q) begin
        next_wa = p_rd_q;
        prev_we = (x_q != tail_q);
        prev_wa = n_rd_q;
        prev_wd = p_rd_q;
      end
    end
    cred_we = 1'b0;
    cred_wd = cred_val + CreditW'(1);
    if (cmd_i.op == CMD_ACCT) begin
      if (cmd_i.act == ACT_CRED_DEC) begin
        cred_we = 1'b1;
        cred_wd = cred_val - CreditW'(1);
      end else if (cmd_i.act == ACT_CRED_INC) begin
        cred_we = (cred_val != {CreditW{1'b1}});
      end
    end
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (acct_chg) rt_mem[ta_q] <= sum;
    if (cred_we) cred_mem[ta_q] <= cred_wd;
    if (cmd_i.op == CMD_READ) begin
      rt_rd_q   <= rt_mem[ta];
      cred_rd_q <= cred_mem[ta];
    end
    if (cmd_i.op == CMD_TAKE_RD) begin
      n_rd_q <= next_mem[x];
      p_rd_q <= prev_mem[x];
    end
  end

  // Payload and work registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_LOAD: begin
        op_q      <= opcode_i;
        c_q       <= core_index_i;
        t_q       <= thread_index_i;
        force_q   <= force_pause_i;
        now_q     <= now_time_i;
        charged_q <= '0;
      end
      CMD_READ: begin
        ta_q     <= ta;
        rtv_rd_q <= rtv_q[ta];
        crv_rd_q <= crv_q[ta];
        el_q     <= now_q - sw_q[c_q];
      end
      CMD_ACCT: begin
        status_q <= cmd_i.status;
        if (acct_chg) charged_q <= sum;
      end
      CMD_PUT1: pp_q <= pp;
      CMD_TAKE_RD: begin
        x_q <= x;
        if (cmd_i.take_head) status_q <= (size_q == '0) ? ST_EMPTY : ST_OK;
      end
      CMD_FIN: begin
        res_status_q  <= status_q;
        res_valid_q   <= cur_ok;
        res_thread_q  <= cur_ok ? cur_q[c_q] : '0;
        res_charged_q <= charged_q;
        res_count_q   <= size_q;
      end
      default: ;
    endcase
  end

  // Queue, flags and core state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      size_q      <= '0;
      inq_q       <= '0;
      paused_q    <= '0;
      blocked_q   <= '1;
      closed_q    <= '1;
      rtv_q       <= '0;
      crv_q       <= '0;
      curv_q      <= '0;
      out_valid_q <= 1'b0;
      pg_q        <= 1'b0;
      tk_go_q     <= 1'b0;
      for (int i = 0; i < NUM_CORES; i++) begin
        cur_q[i] <= '0;
        sw_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      if (cmd_i.op == CMD_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        CMD_ACCT: begin
          case (cmd_i.act)
            ACT_CHARGE: rtv_q[ta_q] <= 1'b1;
            ACT_LAUNCH: begin
              blocked_q[t_q] <= 1'b0;
              closed_q[t_q]  <= 1'b0;
            end
            ACT_PAUSE: begin
              blocked_q[ta_q] <= 1'b1;
              paused_q[ta_q]  <= 1'b1;
              rtv_q[ta_q]     <= 1'b1;
              if (force_q) crv_q[ta_q] <= 1'b0;
            end
            ACT_CRED_DEC, ACT_CRED_INC: begin
              if (cred_we) crv_q[ta_q] <= 1'b1;
            end
            ACT_UNPAUSE: begin
              paused_q[t_q]  <= 1'b0;
              blocked_q[t_q] <= 1'b0;
            end
            default: ;
          endcase
        end
        // Append to tail
        CMD_PUT1: begin
          pg_q <= pg;
          if (pg) begin
            if (size_q == '0) head_q <= pp;
            tail_q    <= pp;
            size_q    <= size_q + CW'(1);
            inq_q[pp] <= 1'b1;
          end
        end
        // Dispatch the head on a tick or pause, and start the unlink
        CMD_TAKE_RD: begin
          tk_go_q <= tk_go;
          if (cmd_i.take_head) begin
            sw_q[c_q] <= now_q;
            if (size_q == '0) begin
              curv_q[c_q] <= 1'b0;
            end else begin
              cur_q[c_q]  <= head_q;
              curv_q[c_q] <= 1'b1;
            end
          end
          if (inq_q[x] && (size_q <= CW'(1))) begin
            head_q   <= '0;
            tail_q   <= '0;
            size_q   <= '0;
            inq_q[x] <= 1'b0;
          end
        end
        // Finish the unlink
        CMD_TAKE_WR: begin
          if (tk_go_q) begin
            if (x_q == head_q) begin
              head_q <= n_rd_q;
            end else if (x_q == tail_q) begin
              tail_q <= p_rd_q;
            end
            size_q     <= size_q - CW'(1);
            inq_q[x_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_status_q;
  assign running_thread_o = res_thread_q;
  assign running_valid_o  = res_valid_q;
  assign charged_time_o   = res_charged_q;
  assign queue_count_o    = res_count_q;

  // Queue occupancy matches the membership flags
  a_size_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(inq_q) == int'(size_q))
    else $error("queue size disagrees with membership flags");

  // Head and tail are members of a non-empty queue
  a_ends_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q != '0) |-> (inq_q[head_q] && inq_q[tail_q]))
    else $error("queue end is not a member");

  // A result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_FIN) |-> !out_valid_q)
    else $error("result register overwritten");

endmodule
